// ===== hw/rtl/edtc_pkg.sv =====
// Shared constants, types and helpers for the duplicate tag classifier.
package edtc_pkg;

   // Table geometry
   localparam int unsigned TABLE_DEPTH = 1024;
   localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
   localparam int unsigned FILL_W      = $clog2(TABLE_DEPTH + 1);

   // Configuration port
   localparam int unsigned CSR_ADDR_W      = 3;
   localparam int unsigned CSR_DATA_W      = 32;
   localparam logic        CSR_IDX_CALL    = 1'b0;
   localparam logic [31:0] CALL_SITE_RESET = 32'h802E_DE98;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   // Result classes
   typedef enum logic [2:0] {
      OUT_TICK    = 3'd0,
      OUT_FIRST   = 3'd1,
      OUT_DIFF    = 3'd2,
      OUT_SAME    = 3'd3,
      OUT_UNKNOWN = 3'd4,
      OUT_FULL    = 3'd5
   } outcome_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   // Saturating increment for the event counters
   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == COUNT_MAX) ? v : v + 32'd1;
   endfunction

endpackage

// ===== hw/rtl/epoch_duplicate_tag_classifier.sv =====
// Top level of the per-tick duplicate tag classifier: scan sequencer, tables and counters.

// Each draw beat forms a 64-bit tag from shape_id and matrix_set_id and is looked up in
// a table of the tags seen since the last tick beat; a tick beat empties the table.
// Tags and owners live in two RAMs of 1024 entries each that are scanned one entry per
// cycle, so a new tag is compared with every filled entry, a repeat stops the scan at
// its hit and a tick skips the scan; the next beat is accepted only in ST_IDLE.
// The result is held in an output register, so the next beat can be accepted while it
// waits; the next result is only written once that register has been taken. The table
// needs no clearing pass after reset: only entries below the fill level are searched.
// All counters saturate at all ones and are read straight off the rsp_*_total ports.
module epoch_duplicate_tag_classifier
   import edtc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input beats
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic [31:0]           req_shape_id,
   input  logic [31:0]           req_matrix_set_id,
   input  logic [31:0]           req_return_address,
   input  logic [31:0]           req_caller_register,
   // result beats
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_outcome,
   output logic                  rsp_owner_known,
   output logic [31:0]           rsp_tick_total,
   output logic [31:0]           rsp_draw_total,
   output logic [31:0]           rsp_owner_draw_total,
   output logic [31:0]           rsp_different_total,
   output logic [31:0]           rsp_same_total,
   output logic [31:0]           rsp_unknown_total,
   output logic [31:0]           rsp_overflow_total,
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Tables
   logic [63:0] tag_mem   [TABLE_DEPTH];
   logic [31:0] owner_mem [TABLE_DEPTH];

   state_type   state_ff, state_in;
   logic [31:0] call_site_ff;

   // Latched beat
   logic        tick_ff;
   logic [63:0] tag_ff;
   logic [31:0] owner_ff;

   // Scan
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic              cmp_valid_ff;
   logic [63:0]       tag_rd_ff;
   logic [31:0]       owner_rd_ff;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [31:0]       prev_owner_ff, prev_owner_in;

   // Counters
   logic [31:0] tick_cnt_ff, tick_cnt_in;
   logic [31:0] draw_cnt_ff, draw_cnt_in;
   logic [31:0] odraw_cnt_ff, odraw_cnt_in;
   logic [31:0] diff_cnt_ff, diff_cnt_in;
   logic [31:0] same_cnt_ff, same_cnt_in;
   logic [31:0] unk_cnt_ff, unk_cnt_in;
   logic [31:0] ovf_cnt_ff, ovf_cnt_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   outcome_type outcome_ff, outcome_in;
   logic        known_ff, known_in;

   // Control
   logic              accept;
   logic              rd_en;
   logic              match;
   logic              emit;
   logic              tag_wr_en;
   logic              owner_wr_en;
   logic [IDX_W-1:0]  wr_idx;
   logic              owner_known;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_CALL) ? call_site_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         call_site_ff <= CALL_SITE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == CSR_IDX_CALL) begin
         call_site_ff <= csr_pwdata;
      end
   end

   assign accept      = req_valid && req_ready;
   assign owner_known = (owner_ff != 32'd0);
   assign match       = cmp_valid_ff && (tag_rd_ff == tag_ff);

   // Sequencer: next state, scan control and result
   always_comb begin
      state_in      = state_ff;
      req_ready     = (state_ff == ST_IDLE);
      rd_en         = 1'b0;
      emit          = 1'b0;
      tag_wr_en     = 1'b0;
      owner_wr_en   = 1'b0;
      wr_idx        = hit_idx_ff;
      scan_in       = scan_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      prev_owner_in = prev_owner_ff;
      fill_in       = fill_ff;
      tick_cnt_in   = tick_cnt_ff;
      draw_cnt_in   = draw_cnt_ff;
      odraw_cnt_in  = odraw_cnt_ff;
      diff_cnt_in   = diff_cnt_ff;
      same_cnt_in   = same_cnt_ff;
      unk_cnt_in    = unk_cnt_ff;
      ovf_cnt_in    = ovf_cnt_ff;
      outcome_in    = outcome_ff;
      known_in      = known_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               scan_in  = '0;
               found_in = 1'b0;
               state_in = req_action ? ST_FINISH : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // one read issued per cycle; its compare lands in the next cycle
            rd_en = (scan_ff < fill_ff);
            if (rd_en) begin
               scan_in = scan_ff + FILL_W'(1);
            end
            if (match) begin
               found_in      = 1'b1;
               hit_idx_in    = cmp_idx_ff;
               prev_owner_in = owner_rd_ff;
               state_in      = ST_FINISH;
            end else if (scan_ff >= fill_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // write back and load the result once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               emit         = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (tick_ff) begin
                  outcome_in  = OUT_TICK;
                  known_in    = 1'b0;
                  tick_cnt_in = sat_inc(tick_cnt_ff);
                  fill_in     = '0;
               end else begin
                  known_in    = owner_known;
                  draw_cnt_in = sat_inc(draw_cnt_ff);
                  if (owner_known) begin
                     odraw_cnt_in = sat_inc(odraw_cnt_ff);
                  end
                  if (found_ff) begin
                     owner_wr_en = 1'b1;
                     if (!owner_known || prev_owner_ff == 32'd0) begin
                        outcome_in = OUT_UNKNOWN;
                        unk_cnt_in = sat_inc(unk_cnt_ff);
                     end else if (owner_ff != prev_owner_ff) begin
                        outcome_in  = OUT_DIFF;
                        diff_cnt_in = sat_inc(diff_cnt_ff);
                     end else begin
                        outcome_in  = OUT_SAME;
                        same_cnt_in = sat_inc(same_cnt_ff);
                     end
                  end else if (fill_ff < FILL_W'(TABLE_DEPTH)) begin
                     tag_wr_en   = 1'b1;
                     owner_wr_en = 1'b1;
                     wr_idx      = fill_ff[IDX_W-1:0];
                     fill_in     = fill_ff + FILL_W'(1);
                     outcome_in  = OUT_FIRST;
                  end else begin
                     outcome_in = OUT_FULL;
                     ovf_cnt_in = sat_inc(ovf_cnt_ff);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         scan_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tick_cnt_ff  <= '0;
         draw_cnt_ff  <= '0;
         odraw_cnt_ff <= '0;
         diff_cnt_ff  <= '0;
         same_cnt_ff  <= '0;
         unk_cnt_ff   <= '0;
         ovf_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         cmp_valid_ff <= rd_en;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         tick_cnt_ff  <= tick_cnt_in;
         draw_cnt_ff  <= draw_cnt_in;
         odraw_cnt_ff <= odraw_cnt_in;
         diff_cnt_ff  <= diff_cnt_in;
         same_cnt_ff  <= same_cnt_in;
         unk_cnt_ff   <= unk_cnt_in;
         ovf_cnt_ff   <= ovf_cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         tick_ff  <= req_action;
         tag_ff   <= {req_shape_id, req_matrix_set_id};
         owner_ff <= (req_return_address == call_site_ff) ? req_caller_register : 32'd0;
      end
      if (rd_en) begin
         cmp_idx_ff <= scan_ff[IDX_W-1:0];
      end
      hit_idx_ff    <= hit_idx_in;
      prev_owner_ff <= prev_owner_in;
      outcome_ff    <= outcome_in;
      known_ff      <= known_in;
   end

   // Tag and owner RAMs: one read port and one write port each
   always_ff @(posedge clock) begin
      if (rd_en) begin
         tag_rd_ff   <= tag_mem[scan_ff[IDX_W-1:0]];
         owner_rd_ff <= owner_mem[scan_ff[IDX_W-1:0]];
      end
      if (tag_wr_en) begin
         tag_mem[wr_idx] <= tag_ff;
      end
      if (owner_wr_en) begin
         owner_mem[wr_idx] <= owner_ff;
      end
   end

   // Result beat
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_outcome          = outcome_ff;
   assign rsp_owner_known      = known_ff;
   assign rsp_tick_total       = tick_cnt_ff;
   assign rsp_draw_total       = draw_cnt_ff;
   assign rsp_owner_draw_total = odraw_cnt_ff;
   assign rsp_different_total  = diff_cnt_ff;
   assign rsp_same_total       = same_cnt_ff;
   assign rsp_unknown_total    = unk_cnt_ff;
   assign rsp_overflow_total   = ovf_cnt_ff;

   // Checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("input accepted twice without finishing the beat");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(TABLE_DEPTH))
      else $error("fill level beyond table depth");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome == OUT_FULL) |-> (fill_ff == FILL_W'(TABLE_DEPTH)))
      else $error("table-full result while table has room");

   a_tick_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome == OUT_TICK) |-> (fill_ff == '0))
      else $error("tick result left entries in the table");

   a_hit_below_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && found_ff) |-> ({1'b0, hit_idx_ff} < fill_ff))
      else $error("hit index outside the filled part of the table");

endmodule

// ===== tb/sv/edtc_outcome_check.sv =====
// Outcome predictor and result comparison for the duplicate tag classifier testbench.
module edtc_outcome_check
   import edtc_pkg::*;
#(
   parameter logic [CSR_ADDR_W-1:0] CALL_SITE_ADDR = '0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_action,
   input  logic [31:0]           req_shape_id,
   input  logic [31:0]           req_matrix_set_id,
   input  logic [31:0]           req_return_address,
   input  logic [31:0]           req_caller_register,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [2:0]            rsp_outcome,
   input  logic                  rsp_owner_known,
   input  logic [31:0]           rsp_tick_total,
   input  logic [31:0]           rsp_draw_total,
   input  logic [31:0]           rsp_owner_draw_total,
   input  logic [31:0]           rsp_different_total,
   input  logic [31:0]           rsp_same_total,
   input  logic [31:0]           rsp_unknown_total,
   input  logic [31:0]           rsp_overflow_total,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    mismatch_count,
   output int                    outcomes_due
);

   // One predicted result beat
   typedef struct packed {
      outcome_type outcome;
      logic        owner_known;
      logic [31:0] tick_total;
      logic [31:0] draw_total;
      logic [31:0] owner_draw_total;
      logic [31:0] different_total;
      logic [31:0] same_total;
      logic [31:0] unknown_total;
      logic [31:0] overflow_total;
   } beat_result_type;

   beat_result_type predicted_results[$];

   // Shadow of the block's tables, counters and call site
   logic [63:0] seen_tags   [TABLE_DEPTH];
   logic [31:0] seen_owners [TABLE_DEPTH];
   int          tags_held;
   logic [31:0] ticks, draws, owner_draws, differents, sames, unknowns, overflows;
   logic [31:0] call_site;

   initial mismatch_count = 0;
   initial outcomes_due = 0;

   function automatic logic [31:0] bumped(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   // Classify one accepted beat and advance the shadow state
   function automatic beat_result_type classify_beat(input logic        tick,
                                                     input logic [31:0] shape,
                                                     input logic [31:0] mset,
                                                     input logic [31:0] ret,
                                                     input logic [31:0] creg);
      beat_result_type r;
      logic [31:0]     owner;
      logic [63:0]     tag;
      int              hit;
      r = '0;
      if (tick) begin
         ticks     = bumped(ticks);
         tags_held = 0;
         r.outcome = OUT_TICK;
      end else begin
         owner = (ret == call_site) ? creg : 32'h0;
         tag   = {shape, mset};
         r.owner_known = (owner != 32'h0);
         draws = bumped(draws);
         if (r.owner_known) owner_draws = bumped(owner_draws);
         hit = -1;
         for (int i = 0; i < tags_held; i++) begin
            if (hit < 0 && seen_tags[i] == tag) hit = i;
         end
         if (hit >= 0) begin
            // repeat within the tick: unknown beats different beats same
            if (owner == 32'h0 || seen_owners[hit] == 32'h0) begin
               r.outcome = OUT_UNKNOWN;
               unknowns  = bumped(unknowns);
            end else if (owner != seen_owners[hit]) begin
               r.outcome  = OUT_DIFF;
               differents = bumped(differents);
            end else begin
               r.outcome = OUT_SAME;
               sames     = bumped(sames);
            end
            seen_owners[hit] = owner;
         end else if (tags_held < TABLE_DEPTH) begin
            seen_tags[tags_held]   = tag;
            seen_owners[tags_held] = owner;
            tags_held++;
            r.outcome = OUT_FIRST;
         end else begin
            r.outcome = OUT_FULL;
            overflows = bumped(overflows);
         end
      end
      r.tick_total       = ticks;
      r.draw_total       = draws;
      r.owner_draw_total = owner_draws;
      r.different_total  = differents;
      r.same_total       = sames;
      r.unknown_total    = unknowns;
      r.overflow_total   = overflows;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Watch both channels and the register port
   always @(posedge clock) begin : watch
      beat_result_type due;
      if (reset) begin
         tags_held   = 0;
         ticks       = '0;
         draws       = '0;
         owner_draws = '0;
         differents  = '0;
         sames       = '0;
         unknowns    = '0;
         overflows   = '0;
         call_site   = CALL_SITE_RESET;
         predicted_results.delete();
         outcomes_due <= 0;
      end else begin
         // result beat against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               $error("result beat with no prediction waiting");
               mismatch_count++;
            end else begin
               due = predicted_results.pop_front();
               check_field("outcome", 32'(due.outcome), 32'(rsp_outcome));
               check_field("owner_known", 32'(due.owner_known), 32'(rsp_owner_known));
               check_field("tick_total", due.tick_total, rsp_tick_total);
               check_field("draw_total", due.draw_total, rsp_draw_total);
               check_field("owner_draw_total", due.owner_draw_total, rsp_owner_draw_total);
               check_field("different_total", due.different_total, rsp_different_total);
               check_field("same_total", due.same_total, rsp_same_total);
               check_field("unknown_total", due.unknown_total, rsp_unknown_total);
               check_field("overflow_total", due.overflow_total, rsp_overflow_total);
            end
         end
         // input beat
         if (req_valid && req_ready) begin
            predicted_results.push_back(classify_beat(req_action, req_shape_id,
                                                      req_matrix_set_id, req_return_address,
                                                      req_caller_register));
         end
         // register access phase
         if (csr_psel && csr_penable && csr_pready && csr_paddr == CALL_SITE_ADDR) begin
            if (csr_pwrite) call_site = csr_pwdata[31:0];
            else check_field("csr_prdata", call_site, csr_prdata[31:0]);
         end
         outcomes_due <= predicted_results.size();
      end
   end

endmodule

// ===== tb/sv/epoch_duplicate_tag_classifier_test.sv =====
// Top of the duplicate tag classifier testbench: clock, reset, stimulus and verdict.
module epoch_duplicate_tag_classifier_test;
   import edtc_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CALL_SITE_ADDR = CSR_ADDR_W'(4 * int'(CSR_IDX_CALL));
   // a draw against a full table scans every entry; stalls come on top
   localparam int QUIET_LIMIT = 50000;
   localparam int BEATS_PER_PHASE = 141;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_action = 1'b0;
   logic [31:0]           req_shape_id = '0;
   logic [31:0]           req_matrix_set_id = '0;
   logic [31:0]           req_return_address = '0;
   logic [31:0]           req_caller_register = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [2:0]            rsp_outcome;
   logic                  rsp_owner_known;
   logic [31:0]           rsp_tick_total;
   logic [31:0]           rsp_draw_total;
   logic [31:0]           rsp_owner_draw_total;
   logic [31:0]           rsp_different_total;
   logic [31:0]           rsp_same_total;
   logic [31:0]           rsp_unknown_total;
   logic [31:0]           rsp_overflow_total;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    mismatch_count;
   int                    outcomes_due;

   // stimulus shaping
   int          send_gap_pct = 0;
   int          rsp_stall_pct = 0;
   logic [31:0] call_site = CALL_SITE_RESET;
   logic [63:0] tag_pool [6];

   epoch_duplicate_tag_classifier uut (.*);

   edtc_outcome_check #(.CALL_SITE_ADDR(CALL_SITE_ADDR)) outcome_check (.*);

   always #5 clock = ~clock;

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // one input beat, with a random gap in front of it
   task automatic send_beat(input logic act, input logic [31:0] shape, input logic [31:0] mset,
                            input logic [31:0] ret, input logic [31:0] creg);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_action          <= act;
      req_shape_id        <= shape;
      req_matrix_set_id   <= mset;
      req_return_address  <= ret;
      req_caller_register <= creg;
      do @(posedge clock); while (!req_ready);
   endtask

   // tick with junk in the ignored fields
   task automatic send_tick();
      send_beat(1'b1, $urandom, $urandom, $urandom, $urandom);
   endtask

   // hold the sender until every outstanding result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outcomes_due != 0);
   endtask

   // write the call site, then read it back
   task automatic program_call_site(input logic [31:0] site);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CALL_SITE_ADDR;
      csr_pwdata  <= site;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      call_site = site;
   endtask

   // draw mostly from the tag pool so that repeats are common
   task automatic send_random_draw();
      logic [63:0] tag;
      logic [31:0] ret;
      logic [31:0] owner;
      if ($urandom_range(9) == 0) tag = {$urandom, $urandom};
      else tag = tag_pool[$urandom_range(5)];
      case ($urandom_range(5))
         0: ret = $urandom;
         1: ret = call_site ^ (32'h1 << $urandom_range(31));
         default: ret = call_site;
      endcase
      case ($urandom_range(9))
         0, 1: owner = '0;
         2: owner = '1;
         3, 4: owner = $urandom;
         default: owner = $urandom_range(3, 1);
      endcase
      send_beat(1'b0, tag[63:32], tag[31:0], ret, owner);
   endtask

   // bursts of draws closed by a tick, under one idling pattern and call site
   task automatic run_phase(input int gap, input int stall, input logic [31:0] site,
                            input int beats);
      int sent;
      drain_results();
      send_gap_pct  = gap;
      rsp_stall_pct = stall;
      program_call_site(site);
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      tag_pool[2] = {$urandom, 32'h0};
      for (int k = 3; k < 6; k++) tag_pool[k] = {$urandom, $urandom};
      sent = 0;
      while (sent < beats) begin
         repeat ($urandom_range(12, 1)) begin
            send_random_draw();
            sent++;
         end
         send_tick();
         sent++;
         // now and then let the block empty completely
         if ($urandom_range(29) == 0) drain_results();
      end
   endtask

   // watchdog on cycles with no beat on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: every outcome class but table full at the reset call site
      send_tick();
      send_beat(1'b0, 32'h0, 32'h0, call_site, 32'h5);
      send_beat(1'b0, 32'h0, 32'h0, call_site, 32'h5);
      send_beat(1'b0, 32'h0, 32'h0, call_site, 32'h7);
      send_beat(1'b0, 32'h0, 32'h0, 32'h0, 32'h7);
      send_beat(1'b0, 32'h0, 32'h0, call_site, 32'h9);
      send_beat(1'b0, '1, '1, call_site, 32'h0);
      send_beat(1'b0, '1, '1, call_site, '1);
      send_beat(1'b0, '1, 32'h0, '1, '1);
      send_beat(1'b0, 32'h0, '1, call_site, 32'h1);
      send_beat(1'b0, '1, 32'h0, call_site, 32'h2);
      send_beat(1'b0, 32'h0, '1, call_site, 32'h1);
      send_beat(1'b0, 32'h0, '1, call_site, 32'h3);
      send_tick();
      send_beat(1'b0, 32'h0, 32'h0, call_site, 32'h5);
      send_tick();

      // random bursts under each idling pattern
      run_phase(0, 0, 32'h0, BEATS_PER_PHASE);
      run_phase(78, 0, 32'hFFFF_FFFF, BEATS_PER_PHASE);
      run_phase(0, 78, $urandom, BEATS_PER_PHASE);
      run_phase(7, 7, CALL_SITE_RESET, BEATS_PER_PHASE);

      drain_results();
      repeat (1100) @(posedge clock);
      if (mismatch_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
